/* src/lfoap_pkg.sv */
package lfoap_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SINE_DEPTH_DEF  = 1024;

  // fixed field widths
  localparam int GAIN_W     = 17;  // 0..65536, Q1.16
  localparam int DIFF_W     = 18;  // signed limit difference
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 16;

  localparam int Q16_ONE  = 65536;
  localparam int Q16_HALF = 32768;

  // sine table generation constants
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;

  // register reset values
  localparam logic [GAIN_W-1:0]     PAN_START_RST  = 17'd0;
  localparam logic [GAIN_W-1:0]     PAN_END_RST    = 17'd65536;
  localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd29185;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_START  = 3'd0,
    CFG_PAN_END    = 3'd1,
    CFG_PHASE_STEP = 3'd2,
    CFG_SINE_SHAPE = 3'd3,
    CFG_MONO_MODE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LFO,
    ST_PAN,
    ST_LEFT,
    ST_RIGHT
  } lfoap_state_t;

  typedef enum logic [1:0] {
    MUL_PAN,
    MUL_LEFT,
    MUL_RIGHT
  } mul_op_t;

  typedef struct packed {
    logic    busy;
    logic    take;
    logic    lfo_load;
    logic    pan_load;
    logic    left_load;
    logic    right_load;
    mul_op_t mul_op;
  } lfoap_ctl_t;

endpackage

/* src/lfoap_sine_rom.sv */
module lfoap_sine_rom
  import lfoap_pkg::*;
#(
  parameter int DEPTH  = SINE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [GAIN_W-1:0] rd_data
);

  logic [GAIN_W-1:0] tbl [DEPTH];
  logic [GAIN_W-1:0] rd_data_r;

  // raised cosine entries 0.5-0.5*cos(2*pi*k/DEPTH) as sin^2 of the half angle,
  // sine by a taylor series in Q2.30, all worked out at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_ent
    localparam logic [63:0] M  = (k <= DEPTH - k) ? 64'(k) : 64'(DEPTH - k);
    localparam logic [63:0] X  = (PI_Q30 * M) / DEPTH;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] S1 = (X >= T1) ? X - T1 : 64'd0;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] S2 = S1 + T2;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] S4 = S3 + T4;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] S6 = S5 + T6;
    localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
    localparam logic [63:0] SC = (S7 > Q30_ONE + 64'd65536) ? Q30_ONE + 64'd65536 : S7;
    localparam logic [63:0] R  = (SC * SC + (64'd1 << 43)) >> 44;
    localparam logic [63:0] RC = (R > 64'd65536) ? 64'd65536 : R;
    assign tbl[k] = RC[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data_r <= tbl[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/lfoap_mul.sv */
module lfoap_mul
  import lfoap_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int A_W         = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W,
  parameter int PROD_W      = A_W + GAIN_W + 1
) (
  input  mul_op_t                  op,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic [GAIN_W-1:0]        lfo,
  input  logic signed [SAMPLE_BITS-1:0] left_smp,
  input  logic signed [SAMPLE_BITS-1:0] right_smp,
  input  logic [GAIN_W-1:0]        gain_l,
  input  logic [GAIN_W-1:0]        gain_r,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [A_W-1:0]    a_op;
  logic signed [GAIN_W:0]   b_op;

  // signed operand times unsigned Q1.16 factor
  always_comb begin
    case (op)
      MUL_PAN: begin
        a_op = A_W'(diff);
        b_op = $signed({1'b0, lfo});
      end
      MUL_LEFT: begin
        a_op = A_W'(left_smp);
        b_op = $signed({1'b0, gain_l});
      end
      MUL_RIGHT: begin
        a_op = A_W'(right_smp);
        b_op = $signed({1'b0, gain_r});
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod = PROD_W'(a_op) * PROD_W'(b_op);

endmodule

/* src/lfoap_ctrl.sv */
module lfoap_ctrl
  import lfoap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_hold,
  output lfoap_ctl_t ctl
);

  lfoap_state_t state_r;
  lfoap_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LFO;
      end
      ST_LFO:   state_nxt = ST_PAN;
      ST_PAN:   state_nxt = ST_LEFT;
      ST_LEFT:  state_nxt = ST_RIGHT;
      ST_RIGHT: begin
        if (!out_hold) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mul_op = MUL_RIGHT;
    case (state_r)
      ST_IDLE: ctl.take = in_valid;
      ST_LFO: begin
        ctl.busy     = 1'b1;
        ctl.lfo_load = 1'b1;
      end
      ST_PAN: begin
        ctl.busy     = 1'b1;
        ctl.pan_load = 1'b1;
        ctl.mul_op   = MUL_PAN;
      end
      ST_LEFT: begin
        ctl.busy      = 1'b1;
        ctl.left_load = 1'b1;
        ctl.mul_op    = MUL_LEFT;
      end
      ST_RIGHT: begin
        ctl.busy       = 1'b1;
        ctl.right_load = !out_hold;
      end
      default: ctl.busy = 1'b1;
    endcase
  end

`ifndef SYNTH
  a_take_then_lfo: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |=> ctl.lfo_load)
    else $error("lfo step did not follow an accepted transaction");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.take, ctl.lfo_load, ctl.pan_load, ctl.left_load, ctl.right_load}))
    else $error("more than one sequencer step active");

  a_hold_blocks_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_hold |-> !ctl.right_load)
    else $error("output register loaded while its transaction is still held");
`endif

endmodule

/* src/lfo_autopan_linear_law_top.sv */
// lfo autopanner, linear pan law, one stereo sample pair per transaction
//
// input channel: in_valid / in_stall with in_left_sample, in_right_sample
// output channel: out_valid / out_stall with out_left_out, out_right_out
// config: cfg_wr_en, cfg_index, cfg_data; registers pan_start, pan_end,
//   phase_step, sine_shape, mono_mode; write only while no transaction is in flight
//
// each transaction walks a five state sequencer around one shared multiplier:
// accept, lfo lookup, pan multiply, left gain multiply, right gain multiply.
// out_valid rises when the right gain multiply loads the output register, after
// the lfo, pan and left steps; the next transaction is accepted only after that,
// so a new pair is not taken before the last one is through all five states
// the result sits in an output register; while the receiver stalls, the next
// transaction is still accepted and worked through to its last multiply,
// where it waits until the output register frees up
//
// reset (synchronous, active low) holds off the input, returns the registers
// to their defaults, clears the lfo phase and empties the output register
module lfo_autopan_linear_law_top
  import lfoap_pkg::*;
#(
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  // config write port
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int A_W        = (SAMPLE_BITS > DIFF_W) ? SAMPLE_BITS : DIFF_W;
  localparam int PROD_W     = A_W + GAIN_W + 1;
  localparam int IDX_PROD_W = PHASE_BITS + ADDR_W + 1;

  lfoap_ctl_t ctl;

  // config registers
  logic [GAIN_W-1:0]     pan_start_r;
  logic [GAIN_W-1:0]     pan_end_r;
  logic [CFG_DATA_W-1:0] phase_step_r;
  logic                  sine_shape_r;
  logic                  mono_mode_r;

  // lfo phase accumulator
  logic [PHASE_BITS-1:0] phase_r;

  // working registers for the transaction in flight
  logic signed [SAMPLE_BITS-1:0] smp_l_r;
  logic signed [SAMPLE_BITS-1:0] smp_r_r;
  logic [GAIN_W-1:0]             lfo_r;
  logic [GAIN_W-1:0]             lfo_nxt;
  logic [GAIN_W-1:0]             gl_r;
  logic [GAIN_W-1:0]             gl_nxt;
  logic [GAIN_W-1:0]             gr_r;
  logic [GAIN_W-1:0]             gr_nxt;
  logic signed [SAMPLE_BITS-1:0] res_l_r;

  // output register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;
  logic signed [SAMPLE_BITS-1:0] out_right_nxt;

  logic                          out_hold;

  // datapath nets
  logic [IDX_PROD_W-1:0]   idx_prod;
  logic [ADDR_W-1:0]       rom_addr;
  logic [GAIN_W-1:0]       rom_q;
  logic [PHASE_BITS:0]     ph_ext;
  logic [PHASE_BITS:0]     ph_neg;
  logic [PHASE_BITS+1:0]   tri_t;
  logic [GAIN_W-1:0]       lfo_tri;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] pan_rnd;
  logic signed [PROD_W-1:0] pan_raw;
  logic [GAIN_W-1:0]       pan_c;
  logic signed [PROD_W-1:0] gain_shr;

  assign out_hold = out_valid_r && out_stall;

  lfoap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_hold (out_hold),
    .ctl      (ctl)
  );

  // no transaction is taken while in reset
  assign in_stall = ctl.busy || !rst_n;

  // config writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_start_r  <= PAN_START_RST;
      pan_end_r    <= PAN_END_RST;
      phase_step_r <= PHASE_STEP_RST;
      sine_shape_r <= 1'b0;
      mono_mode_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PAN_START:  pan_start_r  <= cfg_data[GAIN_W-1:0];
        CFG_PAN_END:    pan_end_r    <= cfg_data[GAIN_W-1:0];
        CFG_PHASE_STEP: phase_step_r <= cfg_data;
        CFG_SINE_SHAPE: sine_shape_r <= cfg_data[0];
        CFG_MONO_MODE:  mono_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // table index is floor(phase * depth / 2^PHASE_BITS); the phase only moves
  // at the end of a transaction, so the registered read is ready by the lfo step
  assign idx_prod = IDX_PROD_W'(phase_r) * IDX_PROD_W'(SINE_TABLE_DEPTH);
  assign rom_addr = idx_prod[PHASE_BITS +: ADDR_W];

  lfoap_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // triangle: twice the distance from the nearer cycle end, top 17 bits
  assign ph_ext  = {1'b0, phase_r};
  assign ph_neg  = {1'b1, {PHASE_BITS{1'b0}}} - ph_ext;
  assign tri_t   = phase_r[PHASE_BITS-1] ? {ph_neg, 1'b0} : {ph_ext, 1'b0};
  assign lfo_tri = tri_t[PHASE_BITS -: GAIN_W];
  assign lfo_nxt = sine_shape_r ? rom_q : lfo_tri;

  // shared multiplier: pan slope, then left gain, then right gain
  assign diff = $signed({1'b0, pan_end_r}) - $signed({1'b0, pan_start_r});

  lfoap_mul #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .A_W         (A_W),
    .PROD_W      (PROD_W)
  ) u_mul (
    .op        (ctl.mul_op),
    .diff      (diff),
    .lfo       (lfo_r),
    .left_smp  (smp_l_r),
    .right_smp (smp_r_r),
    .gain_l    (gl_r),
    .gain_r    (gr_r),
    .prod      (prod)
  );

  // pan = pan_start + round(lfo * diff / 2^16), clamped to 0..1.0
  assign pan_rnd = prod + $signed(PROD_W'(Q16_HALF));
  assign pan_raw = (pan_rnd >>> FRAC_BITS) + $signed(PROD_W'(pan_start_r));

  always_comb begin
    if (pan_raw < $signed(PROD_W'(0))) begin
      pan_c = '0;
    end else if (pan_raw > $signed(PROD_W'(Q16_ONE))) begin
      pan_c = GAIN_W'(Q16_ONE);
    end else begin
      pan_c = pan_raw[GAIN_W-1:0];
    end
  end

  assign gl_nxt = GAIN_W'(Q16_ONE) - pan_c;
  assign gr_nxt = pan_c;

  // gain products floor-shifted by 16, low sample bits kept
  assign gain_shr      = prod >>> FRAC_BITS;
  assign out_right_nxt = mono_mode_r ? '0 : gain_shr[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      smp_l_r <= in_left_sample;
      smp_r_r <= in_right_sample;
    end
    if (ctl.lfo_load) begin
      lfo_r <= lfo_nxt;
    end
    if (ctl.pan_load) begin
      gl_r <= gl_nxt;
      gr_r <= gr_nxt;
    end
    if (ctl.left_load) begin
      res_l_r <= gain_shr[SAMPLE_BITS-1:0];
    end
    if (ctl.right_load) begin
      out_left_r  <= res_l_r;
      out_right_r <= out_right_nxt;
    end
  end

  // phase steps once per finished transaction and wraps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctl.right_load) begin
      phase_r <= phase_r + PHASE_BITS'(phase_step_r);
    end
  end

  always_comb begin
    if (ctl.right_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

`ifndef SYNTH
  a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(ctl.pan_load) |->
      ({1'b0, gl_r} + {1'b0, gr_r}) == (GAIN_W+1)'(Q16_ONE))
    else $error("left and right gains do not sum to unity");

  a_lfo_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(ctl.lfo_load) |-> lfo_r <= GAIN_W'(Q16_ONE))
    else $error("lfo value above unity");

  a_phase_moves: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (phase_r != $past(phase_r)) |-> $past(ctl.right_load))
    else $error("lfo phase moved without a finished transaction");
`endif

endmodule
